FILE: rtl/multi_channel_software_timer_macros.svh
// assertion macros shared by the timer rtl
// expects clk, and for MCST_ASSERT also arst_n, in the scope of each use
`ifndef MULTI_CHANNEL_SOFTWARE_TIMER_MACROS_SVH
`define MULTI_CHANNEL_SOFTWARE_TIMER_MACROS_SVH

// checked only out of reset
`define MCST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MCST_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/mcst_pkg.sv
// shared types and constants of the multi-channel timer
// no dependencies
`timescale 1ns / 1ps

package mcst_pkg;

	localparam int NUM_TIMERS_DEF = 16;

	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_SET    = 3'd1;
	localparam logic [2:0] OP_START  = 3'd2;
	localparam logic [2:0] OP_STOP   = 3'd3;
	localparam logic [2:0] OP_RESET  = 3'd4;
	localparam logic [2:0] OP_HANDLE = 3'd5;

	typedef struct packed {
		logic [2:0]  op;
		logic [3:0]  channel;
		logic [31:0] load_value;
		logic        periodic;
	} cmd_t;

	typedef struct packed {
		logic [15:0] expired_mask;
		logic [15:0] handle;
		logic [31:0] tick_count;
	} res_t;

	typedef struct packed {
		logic idle;
		logic done;
	} stat_t;

endpackage

FILE: rtl/mcst_core.sv
// timer channel table: count/reload ram with read-modify-write sequencer
// depends on mcst_pkg and multi_channel_software_timer_macros.svh
`timescale 1ns / 1ps
`include "multi_channel_software_timer_macros.svh"

module mcst_core #(
	parameter int NUM_TIMERS = mcst_pkg::NUM_TIMERS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  mcst_pkg::cmd_t      cmd,
	input  logic                slot_free,
	output mcst_pkg::stat_t     stat,
	output mcst_pkg::res_t      res
);
	import mcst_pkg::*;

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CW = $clog2(NUM_TIMERS + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_WR   = 3'd2;
	localparam logic [2:0] S_WALK = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	// entry: reload in upper half, remaining count in lower half
	logic [63:0] mem [NUM_TIMERS];
	logic [63:0] rdata_s1;
	logic        rvld_s1;

	logic [2:0]            state_q;
	cmd_t                  cmd_q;
	logic [NUM_TIMERS-1:0] en_q;
	logic [NUM_TIMERS-1:0] rep_q;
	logic [NUM_TIMERS-1:0] wr_q;
	logic [31:0]           ticks_q;
	logic [15:0]           handles_q;
	logic [15:0]           handle_q;
	logic [15:0]           mask_q;
	logic [CW-1:0]         rd_cnt_q;
	logic [CW-1:0]         limit_q;
	logic                  walk_v_s1;
	logic [IW-1:0]         walk_idx_s1;

	logic          ch_ok;
	logic [IW-1:0] ch_idx;
	logic          we;
	logic [IW-1:0] waddr;
	logic [63:0]   wdata;
	logic [IW-1:0] raddr;
	logic          issue;
	logic [63:0]   ent;
	logic [31:0]   dec;
	logic          expire;
	logic [CW-1:0] limit_d;

	assign ch_ok  = 7'(cmd_q.channel) < 7'(NUM_TIMERS);
	assign ch_idx = IW'(cmd_q.channel);
	assign ent    = rvld_s1 ? rdata_s1 : 64'd0;
	assign dec    = ent[31:0] - 32'd1;
	assign expire = (dec == 32'd0);
	assign limit_d = (handles_q >= 16'(NUM_TIMERS)) ? CW'(NUM_TIMERS) : handles_q[CW-1:0];

	always_comb begin
		we    = 1'b0;
		waddr = ch_idx;
		wdata = {cmd_q.load_value, cmd_q.load_value};
		raddr = ch_idx;
		issue = 1'b0;
		case (state_q)
			S_RD: begin
				we = (cmd_q.op == OP_SET) && ch_ok;
			end
			S_WR: begin
				we    = ch_ok;
				wdata = {ent[63:32], ent[63:32]};
			end
			S_WALK: begin
				raddr = rd_cnt_q[IW-1:0];
				issue = rd_cnt_q < limit_q;
				if (walk_v_s1 && en_q[walk_idx_s1]) begin
					we    = 1'b1;
					waddr = walk_idx_s1;
					wdata = expire ? {ent[63:32], ent[63:32]} : {ent[63:32], dec};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			en_q        <= '0;
			rep_q       <= '0;
			wr_q        <= '0;
			ticks_q     <= '0;
			handles_q   <= '0;
			handle_q    <= '0;
			mask_q      <= '0;
			rd_cnt_q    <= '0;
			limit_q     <= '0;
			walk_v_s1   <= 1'b0;
			walk_idx_s1 <= '0;
			rvld_s1     <= 1'b0;
		end else begin
			rvld_s1 <= wr_q[raddr];
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q     <= cmd;
						mask_q    <= '0;
						handle_q  <= '0;
						rd_cnt_q  <= '0;
						walk_v_s1 <= 1'b0;
						limit_q   <= limit_d;
						if (cmd.op == OP_TICK) begin
							ticks_q <= ticks_q + 32'd1;
							state_q <= S_WALK;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_FIN;
					case (cmd_q.op)
						OP_SET: begin
							if (ch_ok) begin
								rep_q[ch_idx] <= cmd_q.periodic;
								wr_q[ch_idx]  <= 1'b1;
							end
						end
						OP_START, OP_RESET: begin
							state_q <= S_WR;
						end
						OP_STOP: begin
							if (ch_ok) begin
								en_q[ch_idx] <= 1'b0;
							end
						end
						OP_HANDLE: begin
							handle_q  <= handles_q;
							handles_q <= handles_q + 16'd1;
						end
						default: begin
						end
					endcase
				end
				S_WR: begin
					if (ch_ok) begin
						en_q[ch_idx] <= (cmd_q.op == OP_START);
						wr_q[ch_idx] <= 1'b1;
					end
					state_q <= S_FIN;
				end
				S_WALK: begin
					walk_v_s1   <= issue;
					walk_idx_s1 <= rd_cnt_q[IW-1:0];
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + CW'(1);
					end
					if (walk_v_s1 && en_q[walk_idx_s1] && expire) begin
						mask_q <= mask_q | (16'd1 << walk_idx_s1);
						if (!rep_q[walk_idx_s1]) begin
							en_q[walk_idx_s1] <= 1'b0;
						end
					end
					if (!walk_v_s1 && !issue) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign stat.idle = (state_q == S_IDLE);
	assign stat.done = (state_q == S_FIN) && slot_free;
	assign res.expired_mask = mask_q;
	assign res.handle       = handle_q;
	assign res.tick_count   = ticks_q;

	`MCST_ASSERT_ALWAYS(a_enabled_written, (en_q & ~wr_q) == '0, "enabled channel never written")
	`MCST_ASSERT(a_done_to_idle, stat.done |=> (state_q == S_IDLE), "no return to idle after done")
	`MCST_ASSERT(a_walk_in_range, (we && state_q == S_WALK) |-> (CW'(walk_idx_s1) < limit_q), "walk write beyond limit")

endmodule

FILE: rtl/multi_channel_software_timer.sv
// Multi-channel one-shot/periodic timer. One word in gives one word out.
// Tick walks channels below min(NUM_TIMERS, handles given), one ram entry
// per cycle, in a walk state and then a finish state; set, stop and get
// handle pass through a read state and the finish state; start and reset
// add a write state between them for the read-modify-write of the count/reload
// ram. in_ready is high only while no word is in work; a finished word waits
// in the output register while the next one is taken.
`timescale 1ns / 1ps
`include "multi_channel_software_timer_macros.svh"

module multi_channel_software_timer #(
	parameter int NUM_TIMERS = mcst_pkg::NUM_TIMERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [3:0]  channel,
	input  logic [31:0] load_value,
	input  logic        periodic,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] expired_mask,
	output logic [15:0] handle,
	output logic [31:0] tick_count
);
	import mcst_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	res_t  res;
	logic  slot_free;
	logic  done;
	res_t  out_q;
	logic  out_valid_q;

	assign cmd.op         = op;
	assign cmd.channel    = channel;
	assign cmd.load_value = load_value;
	assign cmd.periodic   = periodic;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = stat.idle;
	assign done      = stat.done;

	mcst_core #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_valid && in_ready),
		.cmd      (cmd),
		.slot_free(slot_free),
		.stat     (stat),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign expired_mask = out_q.expired_mask;
	assign handle       = out_q.handle;
	assign tick_count   = out_q.tick_count;

	`MCST_ASSERT(a_no_overwrite, done |-> (!out_valid_q || out_ready), "result word overwritten")
	`MCST_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "accepted while busy")
	`MCST_ASSERT(a_out_from_core, $rose(out_valid_q) |-> $past(done), "output word without result")

endmodule
